@@ sv/kfa_pkg.sv @@
// ----------------------------------------------------------------------------
// kfa_pkg: shared types and constants
// Sizes, command and mode codes, and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package kfa_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int TIME_BITS = 16;

    localparam int IW  = $clog2(MAX_KEYS);      // table index
    localparam int CW  = $clog2(MAX_KEYS + 1);  // key count
    localparam int EW  = TIME_BITS + IW;        // elapsed / total time
    localparam int XW  = EW + 1;                // time sums before wrap
    localparam int NW  = TIME_BITS + 8;         // blend numerator
    localparam int RW  = 32 + TIME_BITS;        // table entry: color, duration

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_PLAY   = 3'd2;
    localparam logic [2:0] CMD_STOP   = 3'd3;
    localparam logic [2:0] CMD_REWIND = 3'd4;
    localparam logic [2:0] CMD_TICK   = 3'd5;

    localparam logic [1:0] MODE_ONCE   = 2'd1;
    localparam logic [1:0] MODE_BOUNCE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // table read address select
    localparam logic [1:0] RA_ZERO = 2'd0;
    localparam logic [1:0] RA_LAST = 2'd1;
    localparam logic [1:0] RA_IDX  = 2'd2;
    localparam logic [1:0] RA_NEXT = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  key_red;
        logic [7:0]  key_green;
        logic [7:0]  key_blue;
        logic [7:0]  key_alpha;
        logic [15:0] key_duration;
        logic [15:0] delta_time;
    } t_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       playing;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic       ld_in;
        logic       exec;
        logic       cap_c0;
        logic       cap_last;
        logic       tick_upd;
        logic       srch_chk;
        logic       blend_ld;
        logic       div_step;
        logic       div_done;
        logic       out_load;
        logic [1:0] rsel;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       empty;
        logic       single;
        logic       active;
        logic       tick_end;
        logic       found;
        logic       div_last;
    } t_sts;

endpackage

@@ sv/kfa_if.sv @@
// ----------------------------------------------------------------------------
// kfa_if: channel interfaces
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface kfa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  key_red;
    logic [7:0]  key_green;
    logic [7:0]  key_blue;
    logic [7:0]  key_alpha;
    logic [15:0] key_duration;
    logic [15:0] delta_time;
    modport source (output valid, cmd, key_red, key_green, key_blue, key_alpha,
                    key_duration, delta_time, input ready);
    modport sink (input valid, cmd, key_red, key_green, key_blue, key_alpha,
                  key_duration, delta_time, output ready);
endinterface

interface kfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       playing;
    logic [1:0] status;
    modport source (output valid, out_red, out_green, out_blue, out_alpha, playing,
                    status, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, playing,
                  status, output ready);
endinterface

interface kfa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ sv/keyframe_color_animator.sv @@
// ----------------------------------------------------------------------------
// keyframe_color_animator: RGBA keyframe animation engine
// Keyframe table with loop, play-once and bounce playback and integer blend.
// ----------------------------------------------------------------------------
// Every request (clear, append, play, stop, rewind, tick) returns exactly one
// response with the current color, the playing flag and an append status.
// Requests are handled one at a time; the response sits in an output register
// so the next request is taken while it waits. A rewind or single-key tick
// adds one table read. A full tick reads the last key and updates the time;
// unless a play-once run ends there, the single-read-port keyframe RAM is then
// scanned one entry at a time, each read and then checked, until the segment
// that holds the elapsed time is found, then one more read, the blend
// multiplies and an 8-step restoring divide for all four channels at once.
// play_mode may be written only while idle.
module keyframe_color_animator import kfa_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    kfa_req_if.sink    i_req,
    kfa_rsp_if.source  o_rsp,
    kfa_cfg_if.sink    i_cfg
);
    t_ctl    ctl;
    t_sts    sts;
    t_item   item;
    t_result res;

    // request payload packed for the datapath
    assign item = '{cmd: i_req.cmd, key_red: i_req.key_red, key_green: i_req.key_green,
                    key_blue: i_req.key_blue, key_alpha: i_req.key_alpha,
                    key_duration: i_req.key_duration, delta_time: i_req.delta_time};

    // mode register always accepts
    assign i_cfg.ready = 1'b1;

    kfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    kfa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_res      (res)
    );

    // response fields
    assign o_rsp.out_red   = res.out_red;
    assign o_rsp.out_green = res.out_green;
    assign o_rsp.out_blue  = res.out_blue;
    assign o_rsp.out_alpha = res.out_alpha;
    assign o_rsp.playing   = res.playing;
    assign o_rsp.status    = res.status;
endmodule

@@ sv/kfa_ram.sv @@
// ----------------------------------------------------------------------------
// kfa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ sv/kfa_dp.sv @@
// ----------------------------------------------------------------------------
// kfa_dp: animator datapath
// Keyframe table, time state, segment search, blend multiply and divider.
// ----------------------------------------------------------------------------
module kfa_dp import kfa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  t_ctl    i_ctl,
    output t_sts    o_sts,
    output t_result o_res
);
    logic [2:0]           r_cmd;
    logic [31:0]          r_col_in;
    logic [TIME_BITS-1:0] r_dur_in, r_dt;
    logic [1:0]           r_mode;
    logic [CW-1:0]        r_count;
    logic [EW-1:0]        r_elapsed, r_total;
    logic                 r_active, r_fwd, r_blend_fwd;
    logic [31:0]          r_color;
    logic [1:0]           r_status;
    logic [31:0]          r_last_col, r_prev_col, r_seg_col;
    logic [TIME_BITS-1:0] r_last_dur, r_seg_dur, r_div;
    logic [IW-1:0]        r_idx;
    logic [EW-1:0]        r_acc, r_end;
    logic [TIME_BITS-1:0] r_rem [4];
    logic [7:0]           r_nlo [4];
    logic [7:0]           r_q   [4];
    logic [2:0]           r_dcnt;
    t_result              r_res;

    logic                 we;
    logic [IW-1:0]        raddr;
    logic [RW-1:0]        rdata;
    logic [31:0]          rd_col;
    logic [TIME_BITS-1:0] rd_dur;
    logic [CW-1:0]        idx_p1, cnt_m1;
    logic [IW-1:0]        nidx;
    logic [1:0]           n_status;
    logic                 app_ok;

    assign rd_col = rdata[RW-1:TIME_BITS];
    assign rd_dur = rdata[TIME_BITS-1:0];
    assign idx_p1 = CW'(r_idx) + CW'(1);
    assign cnt_m1 = r_count - CW'(1);
    assign nidx   = (idx_p1 >= r_count) ? '0 : idx_p1[IW-1:0];

    always_comb begin
        app_ok   = 1'b0;
        n_status = ST_OK;
        if (r_cmd == CMD_APPEND) begin
            if (r_count >= CW'(MAX_KEYS)) begin
                n_status = ST_FULL;
            end else if (r_dur_in == '0) begin
                n_status = ST_ZERO;
            end else begin
                app_ok = 1'b1;
            end
        end
    end
    assign we = i_ctl.exec && app_ok;

    always_comb begin
        case (i_ctl.rsel)
            RA_ZERO: raddr = '0;
            RA_LAST: raddr = cnt_m1[IW-1:0];
            RA_IDX:  raddr = r_idx;
            RA_NEXT: raddr = r_blend_fwd ? nidx : r_idx;
            default: raddr = '0;
        endcase
    end

    kfa_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_col_in, r_dur_in}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // tick time update; first duration comes straight off the table port
    logic [XW-1:0] te, tdt, ttot, tfirst, tedge, tsum, tover, tfsum, tunder, tw, n_e;
    logic          n_fwd, n_bfwd, once_end;

    always_comb begin
        te     = XW'(r_elapsed);
        tdt    = XW'(r_dt);
        ttot   = XW'(r_total);
        tfirst = XW'(rd_dur);
        tedge  = ttot - XW'(r_last_dur);
        tsum   = te + tdt;
        tover  = tsum - tedge;
        tfsum  = tfirst + tdt;
        tunder = tfsum - te;
        tw     = tsum - ttot;
        n_e    = tsum;
        n_fwd  = r_fwd;
        n_bfwd = 1'b1;
        once_end = 1'b0;
        case (r_mode)
            MODE_ONCE: begin
                if (tsum > tedge) begin
                    once_end = 1'b1;
                    n_e = (tsum > ttot) ? ttot : tsum;
                end
            end
            MODE_BOUNCE: begin
                if (r_fwd) begin
                    if (tsum > tedge) begin
                        n_fwd = 1'b0;
                        n_e = (tover > ttot - tfirst) ? tfirst : ttot - tover;
                    end
                end else if (te < tfsum) begin
                    n_fwd = 1'b1;
                    n_e = (tunder > tedge) ? tedge : tunder;
                end else begin
                    n_e = te - tdt;
                end
                n_bfwd = n_fwd;
            end
            default: begin
                if (tsum > ttot) begin
                    n_e = (tw > ttot) ? ttot : tw;
                end
            end
        endcase
    end

    // segment search step
    logic [EW-1:0] acc_n;
    logic          found;
    assign acc_n = r_acc + EW'(rd_dur);
    assign found = (acc_n >= r_elapsed) || (idx_p1 == r_count);

    // blend numerators: next*(d-r) + cur*r
    logic [31:0]          ca;
    logic [EW-1:0]        rr;
    logic [TIME_BITS-1:0] rsel, dmr;
    logic [NW-1:0]        num [4];
    always_comb begin
        ca   = r_blend_fwd ? r_seg_col : r_prev_col;
        rr   = (r_end >= r_elapsed) ? r_end - r_elapsed : '0;
        rsel = (rr > EW'(r_seg_dur)) ? r_seg_dur : rr[TIME_BITS-1:0];
        dmr  = r_seg_dur - rsel;
        for (int k = 0; k < 4; k++) begin
            num[k] = NW'(rd_col[8*k +: 8]) * NW'(dmr) + NW'(ca[8*k +: 8]) * NW'(rsel);
        end
    end

    // one restoring divide step per channel
    logic [TIME_BITS:0]   dtry [4];
    logic [TIME_BITS-1:0] n_rem [4];
    logic                 qbit [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dtry[k] = {r_rem[k], r_nlo[k][7]};
            qbit[k] = dtry[k] >= {1'b0, r_div};
            n_rem[k] = qbit[k] ? TIME_BITS'(dtry[k] - {1'b0, r_div})
                               : dtry[k][TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_cmd    <= i_item.cmd;
            r_col_in <= {i_item.key_red, i_item.key_green, i_item.key_blue,
                         i_item.key_alpha};
            r_dur_in <= i_item.key_duration[TIME_BITS-1:0];
            r_dt     <= i_item.delta_time[TIME_BITS-1:0];
        end
        if (i_ctl.cap_last) begin
            r_last_col <= rd_col;
            r_last_dur <= rd_dur;
        end
        if (i_ctl.tick_upd) begin
            r_idx <= '0;
            r_acc <= '0;
        end
        if (i_ctl.srch_chk) begin
            r_acc <= acc_n;
            if (!found || r_idx == '0) begin
                r_prev_col <= rd_col;
            end
            if (found) begin
                r_seg_col <= rd_col;
                r_seg_dur <= rd_dur;
                r_end     <= acc_n;
            end else begin
                r_idx <= idx_p1[IW-1:0];
            end
        end
        if (i_ctl.blend_ld) begin
            r_div  <= r_seg_dur;
            r_dcnt <= '0;
            for (int k = 0; k < 4; k++) begin
                r_rem[k] <= num[k][NW-1:8];
                r_nlo[k] <= num[k][7:0];
                r_q[k]   <= '0;
            end
        end
        if (i_ctl.div_step) begin
            r_dcnt <= r_dcnt + 3'd1;
            for (int k = 0; k < 4; k++) begin
                r_rem[k] <= n_rem[k];
                r_nlo[k] <= {r_nlo[k][6:0], 1'b0};
                r_q[k]   <= {r_q[k][6:0], qbit[k]};
            end
        end
        if (i_ctl.out_load) begin
            r_res <= '{out_red: r_color[31:24], out_green: r_color[23:16],
                       out_blue: r_color[15:8], out_alpha: r_color[7:0],
                       playing: r_active, status: r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_count     <= '0;
            r_elapsed   <= '0;
            r_total     <= '0;
            r_active    <= 1'b0;
            r_fwd       <= 1'b1;
            r_blend_fwd <= 1'b1;
            r_color     <= '1;
            r_status    <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_ctl.exec) begin
                r_status <= n_status;
                case (r_cmd)
                    CMD_CLEAR: begin
                        r_count   <= '0;
                        r_elapsed <= '0;
                        r_total   <= '0;
                        r_active  <= 1'b0;
                        r_fwd     <= 1'b1;
                    end
                    CMD_APPEND: begin
                        if (app_ok) begin
                            if (r_count == '0) begin
                                r_color <= r_col_in;
                            end
                            r_count <= r_count + CW'(1);
                            r_total <= r_total + EW'(r_dur_in);
                        end
                    end
                    CMD_PLAY:   r_active <= 1'b1;
                    CMD_STOP:   r_active <= 1'b0;
                    CMD_REWIND: begin
                        r_elapsed <= '0;
                        r_fwd     <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_ctl.cap_c0) begin
                r_color <= rd_col;
            end
            if (i_ctl.tick_upd) begin
                r_elapsed   <= n_e[EW-1:0];
                r_fwd       <= n_fwd;
                r_blend_fwd <= n_bfwd;
                if (once_end) begin
                    r_color  <= r_last_col;
                    r_active <= 1'b0;
                end
            end
            if (i_ctl.div_done) begin
                r_color <= {r_q[3], r_q[2], r_q[1], r_q[0]};
            end
        end
    end

    assign o_sts = '{cmd: r_cmd, empty: (r_count == '0), single: (r_count == CW'(1)),
                     active: r_active, tick_end: once_end, found: found,
                     div_last: (r_dcnt == 3'd7)};
    assign o_res = r_res;
endmodule

@@ sv/kfa_ctrl.sv @@
// ----------------------------------------------------------------------------
// kfa_ctrl: animator sequencer
// Walks each request through decode, table reads, search, blend and divide.
// ----------------------------------------------------------------------------
module kfa_ctrl import kfa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RD0  = 4'd2;
    localparam logic [3:0] S_CAP0 = 4'd3;
    localparam logic [3:0] S_TRL  = 4'd4;
    localparam logic [3:0] S_TRF  = 4'd5;
    localparam logic [3:0] S_TUPD = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SCHK = 4'd8;
    localparam logic [3:0] S_NRD  = 4'd9;
    localparam logic [3:0] S_NCAP = 4'd10;
    localparam logic [3:0] S_DIV  = 4'd11;
    localparam logic [3:0] S_WR   = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctl = '0;
        o_ctl.rsel = RA_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.ld_in = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                case (i_sts.cmd)
                    CMD_REWIND: n_state = i_sts.empty ? S_FIN : S_RD0;
                    CMD_TICK: begin
                        if (!i_sts.active || i_sts.empty) begin
                            n_state = S_FIN;
                        end else if (i_sts.single) begin
                            n_state = S_RD0;
                        end else begin
                            n_state = S_TRL;
                        end
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_RD0:  n_state = S_CAP0;
            S_CAP0: begin
                o_ctl.cap_c0 = 1'b1;
                n_state = S_FIN;
            end
            S_TRL: begin
                o_ctl.rsel = RA_LAST;
                n_state = S_TRF;
            end
            S_TRF: begin
                o_ctl.cap_last = 1'b1;
                n_state = S_TUPD;
            end
            S_TUPD: begin
                o_ctl.tick_upd = 1'b1;
                n_state = i_sts.tick_end ? S_FIN : S_SRD;
            end
            S_SRD: begin
                o_ctl.rsel = RA_IDX;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                o_ctl.srch_chk = 1'b1;
                n_state = i_sts.found ? S_NRD : S_SRD;
            end
            S_NRD: begin
                o_ctl.rsel = RA_NEXT;
                n_state = S_NCAP;
            end
            S_NCAP: begin
                o_ctl.blend_ld = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_ctl.div_done = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
